@@ src/dss_pkg.sv @@
// Shared types, constants and codes for the drum step sequencer.
`default_nettype none
package dss_pkg;

	// Geometry of the pattern grid
	localparam int TRACKS = 4;
	localparam int STEPS  = 16;
	localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int POS_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int LEN_W  = 10;
	localparam int NOTE_W = 7;

	// Result queue sizing
	localparam int FIFO_DEPTH = 16;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	// Message and tempo constants
	localparam logic [NOTE_W-1:0] VEL_ON      = 7'd100;
	localparam logic [7:0]        TEMPO_MIN   = 8'd40;
	localparam logic [7:0]        TEMPO_MAX   = 8'd240;
	localparam logic [7:0]        TEMPO_RESET = 8'd120;

	// Configuration register map
	localparam logic [2:0] CFG_NOTE_BASE = 3'd0;
	localparam logic [2:0] CFG_LEN_BASE  = 3'd4;
	localparam logic [NOTE_W-1:0] NOTE_RESET [4] = '{7'd36, 7'd38, 7'd42, 7'd46};
	localparam logic [LEN_W-1:0]  LEN_RESET  [4] = '{10'd200, 10'd150, 10'd50, 10'd300};

	// Input operation codes
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_STEP     = 3'd1,
		OP_TOGGLE   = 3'd2,
		OP_CLEAR    = 3'd3,
		OP_PLAY     = 3'd4,
		OP_STOP     = 3'd5,
		OP_TEMPO_DN = 3'd6,
		OP_TEMPO_UP = 3'd7
	} op_e;

	// Input transaction payload
	typedef struct packed {
		logic [2:0] op;
		logic [1:0] cell_track;
		logic [3:0] cell_step;
		logic       link_up;
	} in_item_t;

	// Result transaction payload
	typedef struct packed {
		logic              msg_valid;
		logic              is_note_on;
		logic [NOTE_W-1:0] note_number;
		logic [NOTE_W-1:0] velocity;
		logic [1:0]        msg_track;
		logic [3:0]        position;
		logic              running;
		logic [7:0]        tempo_bpm;
		logic              last;
	} out_item_t;

	// One entry of the per-track memory
	typedef struct packed {
		logic [STEPS-1:0] row;
		logic [LEN_W-1:0] cnt;
	} trk_entry_t;

	// Command context handed to the per-track update
	typedef struct packed {
		logic [2:0]       op;
		logic             link;
		logic             play_before;
		logic             cell_ok;
		logic [TRK_W-1:0] sel_trk;
		logic [POS_W-1:0] col;
	} trk_cmd_t;

	// Per-track update verdict
	typedef struct packed {
		logic msg_v;
		logic msg_on;
	} trk_msg_t;

endpackage
`default_nettype wire

@@ src/dss_track_mem.sv @@
// Per-track state memory: pattern row and release countdown, with write bypass.
`default_nettype none
module dss_track_mem (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      we,
	input  wire [dss_pkg::TRK_W-1:0] waddr,
	input  dss_pkg::trk_entry_t      wdata,
	input  wire                      re,
	input  wire [dss_pkg::TRK_W-1:0] raddr,
	output dss_pkg::trk_entry_t      rdata
);
	import dss_pkg::*;

	trk_entry_t          track_mem_q [TRACKS];
	logic [TRACKS-1:0]   entry_vld_q;
	trk_entry_t          rdata_q;

	// Storage array, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			track_mem_q[waddr] <= wdata;
		end
	end

	// Entry valid bits: an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
		end else if (we) begin
			entry_vld_q[waddr] <= 1'b1;
		end
	end

	// Registered read, new data wins on a same-entry write
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else if (entry_vld_q[raddr]) begin
				rdata_q <= track_mem_q[raddr];
			end else begin
				rdata_q <= '0;
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ src/dss_track_update.sv @@
// Read-modify-write logic for one track entry under one command.
`default_nettype none
module dss_track_update (
	input  dss_pkg::trk_cmd_t        cmd,
	input  wire [dss_pkg::TRK_W-1:0] trk,
	input  dss_pkg::trk_entry_t      cur,
	input  wire [dss_pkg::LEN_W-1:0] len,
	output dss_pkg::trk_entry_t      nxt,
	output dss_pkg::trk_msg_t        msg
);
	import dss_pkg::*;

	always_comb begin
		nxt = cur;
		msg = '0;
		case (op_e'(cmd.op))
			OP_TICK: begin
				// countdown, note-off on reaching zero
				if (cur.cnt != '0) begin
					nxt.cnt   = cur.cnt - 1'b1;
					msg.msg_v = (cur.cnt == LEN_W'(1));
				end
			end
			OP_STEP: begin
				// note-on for a set cell, retrigger reloads the countdown
				if (cmd.play_before && cmd.link && cur.row[cmd.col]) begin
					nxt.cnt    = (len == '0) ? LEN_W'(1) : len;
					msg.msg_v  = 1'b1;
					msg.msg_on = 1'b1;
				end
			end
			OP_TOGGLE: begin
				if (cmd.cell_ok && (trk == cmd.sel_trk)) begin
					nxt.row[cmd.col] = ~cur.row[cmd.col];
				end
			end
			OP_CLEAR: begin
				nxt.row = '0;
			end
			OP_PLAY, OP_STOP: begin
				// flush a pending note (play acts as stop only while running)
				if (((op_e'(cmd.op) == OP_STOP) || cmd.play_before) && (cur.cnt != '0)) begin
					nxt.cnt   = '0;
					msg.msg_v = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/dss_msg_fifo.sv @@
// Result queue between the track sweep and the output channel.
`default_nettype none
module dss_msg_fifo (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  dss_pkg::out_item_t        push_data,
	input  wire                       pop,
	output dss_pkg::out_item_t        head,
	output logic [dss_pkg::FCNT_W-1:0] count
);
	import dss_pkg::*;

	out_item_t          slot_q [FIFO_DEPTH];
	logic [FPTR_W-1:0]  wptr_q;
	logic [FPTR_W-1:0]  rptr_q;
	logic [FCNT_W-1:0]  cnt_q;

	// Slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head  = slot_q[rptr_q];
	assign count = cnt_q;

endmodule
`default_nettype wire

@@ src/drum_step_sequencer_unit.sv @@
// Top level of the four-track, sixteen-step drum pattern sequencer.
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one command transaction: ms tick,
//   sixteenth step, cell toggle, grid clear, play toggle, stop or tempo step.
//   out channel (out_valid/out_ready/out_data) returns one result per MIDI message
//   in track order, or one empty result when a command sends nothing; the final
//   result of each command has last set. Status fields give the state after it.
//   cfg_we/cfg_idx/cfg_wdata write the note numbers (0..3) and lengths (4..7).
// Sweep:
//   A command occupies the track memory port for one read per track, one track
//   entry read, updated and written back per cycle, so a new command is taken
//   only once the sweep of the last one has been issued. Its last result is queued
//   from the finish stage and reaches the port in the cycle after when the queue is empty.
// Stalls: results wait in a 16-entry queue; in_ready drops while the queue
//   cannot hold the worst-case output of every command in flight.
// Reset: grid and countdowns clear, position 0, stopped, tempo 120, and the
//   note and length registers return to their defaults. No clearing pass is
//   needed; the block accepts commands right after reset.
`default_nettype none
module drum_step_sequencer_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  dss_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output dss_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire [2:0]           cfg_idx,
	input  wire [9:0]           cfg_wdata
);
	import dss_pkg::*;

	typedef struct packed {
		logic [3:0] position;
		logic       running;
		logic [7:0] tempo_bpm;
	} stat_t;

	typedef struct packed {
		trk_cmd_t cmd;
		stat_t    stat;
	} item_ctx_t;

	typedef struct packed {
		logic              on;
		logic [1:0]        trk;
		logic [NOTE_W-1:0] note;
	} held_msg_t;

	// Configuration registers
	logic [NOTE_W-1:0] note_q [4];
	logic [LEN_W-1:0]  len_q  [4];

	// Global sequencer state
	logic [POS_W-1:0] pos_q;
	logic             play_q;
	logic [7:0]       tempo_q;

	// Issue control
	logic             iss_busy_q;
	logic [TRK_W-1:0] iss_trk_q;
	item_ctx_t        ctx_q;

	// Read-data stage
	logic             v_s1;
	logic             first_s1;
	logic             last_s1;
	logic [TRK_W-1:0] trk_s1;
	item_ctx_t        ctx_s1;

	// Finish stage
	logic             fin_v_s2;
	stat_t            fin_stat_s2;

	// Held message and in-flight count
	logic             held_v_q;
	held_msg_t        held_q;
	logic [1:0]       inflight_q;

	logic             accept;
	logic             rd_en;
	logic [TRK_W-1:0] rd_addr;
	logic             rd_last;
	item_ctx_t        ctx_new;
	item_ctx_t        ctx_n;
	logic [POS_W-1:0] pos_n;
	logic             play_n;
	logic [7:0]       tempo_n;
	trk_entry_t       rd_entry;
	trk_entry_t       wr_entry;
	trk_msg_t         upd_msg;
	held_msg_t        new_msg;
	logic             mid_push;
	logic             push;
	out_item_t        push_data;
	logic [FCNT_W-1:0] fifo_cnt;
	logic             credit_ok;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				note_q[i] <= NOTE_RESET[i];
				len_q[i]  <= LEN_RESET[i];
			end
		end else if (cfg_we) begin
			if (cfg_idx < CFG_LEN_BASE) begin
				note_q[2'(cfg_idx - CFG_NOTE_BASE)] <= cfg_wdata[NOTE_W-1:0];
			end else begin
				len_q[2'(cfg_idx - CFG_LEN_BASE)] <= cfg_wdata[LEN_W-1:0];
			end
		end
	end

	// Admission: room in the queue for every command in flight plus this one
	assign credit_ok = (32'(fifo_cnt) + TRACKS * (32'(inflight_q) + 1)) <= FIFO_DEPTH;
	assign in_ready  = !iss_busy_q && credit_ok;
	assign accept    = in_valid && in_ready;

	// Global state update and command context at acceptance
	always_comb begin
		pos_n   = pos_q;
		play_n  = play_q;
		tempo_n = tempo_q;
		case (op_e'(in_data.op))
			OP_STEP: begin
				if (play_q) begin
					pos_n = (pos_q == POS_W'(STEPS - 1)) ? '0 : pos_q + 1'b1;
				end
			end
			OP_PLAY: begin
				if (play_q) begin
					play_n = 1'b0;
				end else begin
					pos_n  = '0;
					play_n = 1'b1;
				end
			end
			OP_STOP: begin
				play_n = 1'b0;
			end
			OP_TEMPO_DN: begin
				if (tempo_q > TEMPO_MIN) begin
					tempo_n = tempo_q - 1'b1;
				end
			end
			OP_TEMPO_UP: begin
				if (tempo_q < TEMPO_MAX) begin
					tempo_n = tempo_q + 1'b1;
				end
			end
			default: begin
				pos_n = pos_q;
			end
		endcase

		ctx_new.cmd.op          = in_data.op;
		ctx_new.cmd.link        = in_data.link_up;
		ctx_new.cmd.play_before = play_q;
		ctx_new.cmd.cell_ok     = (32'(in_data.cell_track) < TRACKS) &&
		                          (32'(in_data.cell_step) < STEPS);
		ctx_new.cmd.sel_trk     = TRK_W'(in_data.cell_track);
		ctx_new.cmd.col         = (op_e'(in_data.op) == OP_TOGGLE) ?
		                          POS_W'(in_data.cell_step) : pos_q;
		ctx_new.stat.position   = 4'(pos_n);
		ctx_new.stat.running    = play_n;
		ctx_new.stat.tempo_bpm  = tempo_n;
		ctx_n = accept ? ctx_new : ctx_q;
	end

	// Track read issue: track 0 at acceptance, the rest on following cycles
	assign rd_en   = accept || iss_busy_q;
	assign rd_addr = accept ? '0 : iss_trk_q;
	assign rd_last = accept ? (TRACKS == 1) : (iss_trk_q == TRK_W'(TRACKS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			play_q     <= 1'b0;
			tempo_q    <= TEMPO_RESET;
			iss_busy_q <= 1'b0;
			iss_trk_q  <= '0;
		end else begin
			if (accept) begin
				pos_q      <= pos_n;
				play_q     <= play_n;
				tempo_q    <= tempo_n;
				iss_busy_q <= (TRACKS > 1);
				iss_trk_q  <= TRK_W'(1);
			end else if (iss_busy_q) begin
				iss_trk_q <= iss_trk_q + 1'b1;
				if (rd_last) begin
					iss_busy_q <= 1'b0;
				end
			end
		end
	end

	// Command context, read stage and finish status registers
	always_ff @(posedge clk) begin
		ctx_q <= ctx_n;
		if (rd_en) begin
			ctx_s1 <= ctx_n;
			trk_s1 <= rd_addr;
		end
		if (v_s1 && last_s1) begin
			fin_stat_s2 <= ctx_s1.stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			fin_v_s2 <= 1'b0;
		end else begin
			v_s1     <= rd_en;
			first_s1 <= accept;
			last_s1  <= rd_en && rd_last;
			fin_v_s2 <= v_s1 && last_s1;
		end
	end

	// Track state memory
	dss_track_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (v_s1),
		.waddr  (trk_s1),
		.wdata  (wr_entry),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata  (rd_entry)
	);

	// Per-track update
	dss_track_update u_upd (
		.cmd (ctx_s1.cmd),
		.trk (trk_s1),
		.cur (rd_entry),
		.len (len_q[2'(trk_s1)]),
		.nxt (wr_entry),
		.msg (upd_msg)
	);

	assign new_msg.on   = upd_msg.msg_on;
	assign new_msg.trk  = 2'(trk_s1);
	assign new_msg.note = note_q[2'(trk_s1)];

	// One message is held back so the final one can carry last
	assign mid_push = v_s1 && !first_s1 && upd_msg.msg_v && held_v_q;
	assign push     = fin_v_s2 || mid_push;

	always_comb begin
		push_data = '0;
		if (fin_v_s2) begin
			if (held_v_q) begin
				push_data.msg_valid   = 1'b1;
				push_data.is_note_on  = held_q.on;
				push_data.note_number = held_q.note;
				push_data.velocity    = held_q.on ? VEL_ON : '0;
				push_data.msg_track   = held_q.trk;
			end
			push_data.position  = fin_stat_s2.position;
			push_data.running   = fin_stat_s2.running;
			push_data.tempo_bpm = fin_stat_s2.tempo_bpm;
			push_data.last      = 1'b1;
		end else begin
			push_data.msg_valid   = 1'b1;
			push_data.is_note_on  = held_q.on;
			push_data.note_number = held_q.note;
			push_data.velocity    = held_q.on ? VEL_ON : '0;
			push_data.msg_track   = held_q.trk;
			push_data.position    = ctx_s1.stat.position;
			push_data.running     = ctx_s1.stat.running;
			push_data.tempo_bpm   = ctx_s1.stat.tempo_bpm;
			push_data.last        = 1'b0;
		end
	end

	// Held message and in-flight command count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q   <= 1'b0;
			inflight_q <= '0;
		end else begin
			if (v_s1 && first_s1) begin
				held_v_q <= upd_msg.msg_v;
			end else if (v_s1 && upd_msg.msg_v) begin
				held_v_q <= 1'b1;
			end
			case ({accept, fin_v_s2})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && upd_msg.msg_v) begin
			held_q <= new_msg;
		end
	end

	// Result queue
	dss_msg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (out_valid && out_ready),
		.head      (out_data),
		.count     (fifo_cnt)
	);

	assign out_valid = (fifo_cnt != '0);

`ifndef SYNTHESIS
	// The admission check must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt != FCNT_W'(FIFO_DEPTH)))
		else $error("result queue overflow");

	// A finishing command never collides with a mid-sweep push
	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v_s2 |-> !mid_push)
		else $error("two result pushes in one cycle");

	// At most two commands are between acceptance and finish
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("in-flight command count out of range");

	// An accepted command starts its sweep with track zero next cycle
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (v_s1 && first_s1 && (trk_s1 == '0)))
		else $error("sweep did not start on track zero");
`endif

endmodule
`default_nettype wire
